// ----- sv/double_ended_queue_defines.svh -----
// assertion macros shared by the double-ended queue rtl
// no dependencies; included by the controller and the datapath
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

`define DEQ_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define DEQ_NEVER(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`else

`define DEQ_ASSERT(name, clk, rst_n, prop, msg)

`define DEQ_NEVER(name, clk, rst_n, prop, msg)

`endif

`endif

// ----- sv/deq_pkg.sv -----
// shared types, constants and ring index helper for the double-ended queue
// no dependencies
package deq_pkg;

    localparam int DEPTH  = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        F_PUSH_FRONT = 3'd0,
        F_PUSH_REAR  = 3'd1,
        F_POP_FRONT  = 3'd2,
        F_POP_REAR   = 3'd3,
        F_DUMP_FWD   = 3'd4,
        F_DUMP_BWD   = 3'd5
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_PUSHED    = 3'd0,
        ST_POPPED    = 3'd1,
        ST_LISTED    = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_EMPTY     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_DUMP
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH_FRONT,
        OP_PUSH_REAR,
        OP_POP_FRONT,
        OP_POP_REAR,
        OP_DUMP_START,
        OP_DUMP_NEXT
    } t_dp_op;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_VALUE,
        SRC_MEM
    } t_out_src;

    typedef struct packed {
        logic     capture;
        t_dp_op   op;
        logic     out_load;
        t_out_src out_src;
        t_status  out_status;
        logic     out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              empty;
        logic              full;
        logic              out_free;
        logic              dump_last;
    } t_dp_stat;

    // (base + off) mod DEPTH, both operands below DEPTH
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IDX_W+1)'(DEPTH)) begin
            sum = sum - (IDX_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ----- sv/deq_if.sv -----
// request and response channel interfaces of the double-ended queue
// depends on deq_pkg
interface deq_req_if import deq_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [WORD_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink (input valid, input func, input value, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] value_out;
    logic [STAT_W-1:0]        status;
    logic                     last;

    modport source (output valid, output value_out, output status, output last, input ready);
    modport sink (input valid, input value_out, input status, input last, output ready);
endinterface

// ----- sv/deq_ctrl.sv -----
// controller state machine of the double-ended queue
// depends on deq_pkg and double_ended_queue_defines.svh
`include "double_ended_queue_defines.svh"

module deq_ctrl import deq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd.capture    = 1'b0;
        o_cmd.op         = OP_NONE;
        o_cmd.out_load   = 1'b0;
        o_cmd.out_src    = SRC_ZERO;
        o_cmd.out_status = ST_PUSHED;
        o_cmd.out_last   = 1'b1;
        case (r_state)
            S_IDLE: begin
                // a new request is taken even while a result waits
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                    case (i_stat.func)
                        F_PUSH_FRONT, F_PUSH_REAR: begin
                            o_cmd.out_load = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.out_status = ST_OVERFLOW;
                            end else begin
                                o_cmd.op         = (i_stat.func == F_PUSH_FRONT) ?
                                                   OP_PUSH_FRONT : OP_PUSH_REAR;
                                o_cmd.out_src    = SRC_VALUE;
                                o_cmd.out_status = ST_PUSHED;
                            end
                        end
                        F_POP_FRONT, F_POP_REAR: begin
                            if (i_stat.empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = ST_UNDERFLOW;
                            end else begin
                                o_cmd.op = (i_stat.func == F_POP_FRONT) ?
                                           OP_POP_FRONT : OP_POP_REAR;
                                n_state  = S_POP_WAIT;
                            end
                        end
                        F_DUMP_FWD, F_DUMP_BWD: begin
                            if (i_stat.empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = ST_EMPTY;
                            end else begin
                                o_cmd.op = OP_DUMP_START;
                                n_state  = S_DUMP;
                            end
                        end
                        default: begin
                            // unused codes give no result
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_POP_WAIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_src    = SRC_MEM;
                    o_cmd.out_status = ST_POPPED;
                    n_state          = S_IDLE;
                end
            end
            S_DUMP: begin
                // read data holds until the output slot frees up
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_src    = SRC_MEM;
                    o_cmd.out_status = ST_LISTED;
                    o_cmd.out_last   = i_stat.dump_last;
                    if (i_stat.dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.op = OP_DUMP_NEXT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `DEQ_ASSERT(a_req_to_exec, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (r_state == S_EXEC), "accepted request did not start")
    `DEQ_NEVER(a_dump_nonempty, i_clk, i_rst_n, (r_state == S_DUMP) && i_stat.empty, "listing an empty deque")
    `DEQ_ASSERT(a_last_to_idle, i_clk, i_rst_n, (o_cmd.out_load && o_cmd.out_last) |=> (r_state == S_IDLE), "final result did not end the request")

endmodule

// ----- sv/deq_dp.sv -----
// datapath of the double-ended queue: ring memory, pointers, output register
// depends on deq_pkg and double_ended_queue_defines.svh
`include "double_ended_queue_defines.svh"

module deq_dp import deq_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic [FUNC_W-1:0]        i_func,
    input  logic signed [WORD_W-1:0] i_value,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic signed [WORD_W-1:0] o_value_out,
    output logic [STAT_W-1:0]        o_status,
    output logic                     o_last
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    logic [FUNC_W-1:0]        r_func;
    logic signed [WORD_W-1:0] r_value;
    logic [IDX_W-1:0]         r_head;
    logic [CNT_W-1:0]         r_count;
    logic [IDX_W-1:0]         r_iter;

    logic                     r_out_valid;
    logic signed [WORD_W-1:0] r_out_value;
    t_status                  r_out_status;
    logic                     r_out_last;

    logic [CNT_W-1:0] cnt_m1;
    logic [IDX_W-1:0] head_m1;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] rd_off;
    logic [IDX_W-1:0] dump_k;
    logic             mem_we;
    logic             mem_re;
    logic             out_free;

    assign cnt_m1   = r_count - CNT_W'(1);
    assign head_m1  = ring_add(r_head, IDX_W'(DEPTH - 1));
    assign out_free = !r_out_valid || i_out_ready;

    assign mem_we = (i_cmd.op == OP_PUSH_FRONT) || (i_cmd.op == OP_PUSH_REAR);
    assign mem_re = (i_cmd.op == OP_POP_FRONT) || (i_cmd.op == OP_POP_REAR) ||
                    (i_cmd.op == OP_DUMP_START) || (i_cmd.op == OP_DUMP_NEXT);

    assign wr_addr = (i_cmd.op == OP_PUSH_FRONT) ? head_m1 :
                     ring_add(r_head, r_count[IDX_W-1:0]);

    // offset from the head of the entry to read
    always_comb begin
        dump_k = (i_cmd.op == OP_DUMP_NEXT) ? (r_iter + IDX_W'(1)) : '0;
        case (i_cmd.op)
            OP_POP_REAR: rd_off = cnt_m1[IDX_W-1:0];
            OP_DUMP_START, OP_DUMP_NEXT: begin
                rd_off = (r_func == F_DUMP_FWD) ? dump_k : (cnt_m1[IDX_W-1:0] - dump_k);
            end
            default: rd_off = '0;
        endcase
    end

    assign rd_addr = ring_add(r_head, rd_off);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= r_value;
        end
        if (mem_re) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= i_func;
            r_value <= i_value;
        end
        if (i_cmd.op == OP_DUMP_START) begin
            r_iter <= '0;
        end else if (i_cmd.op == OP_DUMP_NEXT) begin
            r_iter <= dump_k;
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_last   <= i_cmd.out_last;
            case (i_cmd.out_src)
                SRC_VALUE: r_out_value <= r_value;
                SRC_MEM:   r_out_value <= r_rdata;
                default:   r_out_value <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_PUSH_FRONT: begin
                    r_head  <= head_m1;
                    r_count <= r_count + CNT_W'(1);
                end
                OP_PUSH_REAR: r_count <= r_count + CNT_W'(1);
                OP_POP_FRONT: begin
                    r_head  <= ring_add(r_head, IDX_W'(1));
                    r_count <= cnt_m1;
                end
                OP_POP_REAR: r_count <= cnt_m1;
                default: ;
            endcase
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.func      = r_func;
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CNT_W'(DEPTH));
    assign o_stat.out_free  = out_free;
    assign o_stat.dump_last = ((CNT_W'(r_iter) + CNT_W'(1)) == r_count);

    assign o_out_valid = r_out_valid;
    assign o_value_out = r_out_value;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

    `DEQ_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "entry count beyond depth")
    `DEQ_NEVER(a_push_full, i_clk, i_rst_n, mem_we && o_stat.full, "push into a full deque")
    `DEQ_NEVER(a_load_busy, i_clk, i_rst_n, i_cmd.out_load && !out_free, "result overwrote a waiting result")
    `DEQ_ASSERT(a_pop_count, i_clk, i_rst_n, ((i_cmd.op == OP_POP_FRONT) || (i_cmd.op == OP_POP_REAR)) |=> (r_count == $past(cnt_m1)), "pop did not shrink the deque")

endmodule

// ----- sv/double_ended_queue.sv -----
// Bounded double-ended queue of DEPTH (32) signed 32-bit words in a ring
// buffer with a head index and an entry count. Each request carries one
// operation; every result comes on the response channel and the final one of
// a request has last set. Push, overflow, underflow and empty-dump requests
// go through accept and execute; a pop also waits while the entry is read
// through the registered read port of the ring memory; a dump lists one
// entry per cycle through that same read port while the response side does
// not stall. The output register holds a finished result while the next
// request is accepted.
// depends on deq_pkg, deq_if, deq_ctrl and deq_dp
module double_ended_queue import deq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    deq_req_if.sink   i_req,
    deq_rsp_if.source o_rsp
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     in_ready;

    deq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    deq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_func      (i_req.func),
        .i_value     (i_req.value),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_value_out (o_rsp.value_out),
        .o_status    (o_rsp.status),
        .o_last      (o_rsp.last)
    );

    assign i_req.ready = in_ready;

endmodule
